### sv/tccs_pkg.sv
package tccs_pkg;

  // default geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // field widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CFG_IDX_W = 1;

  // commands
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_MAX = 8'h7F;
  localparam int TAB_STOP = 8;

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_ATTR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_ATTR = 1'd1;
  localparam logic [ATTR_W-1:0] CHAR_ATTR_RST  = 8'h02;
  localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'h0F;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_address;
  } tccs_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_location;
    logic [CELL_W-1:0] cell_value;
  } tccs_out_t;

  // what a put of the presented code does
  typedef struct packed {
    logic print;
    logic scroll;
  } cur_status_t;

endpackage

### sv/tccs_cell_store.sv
module tccs_cell_store #(
  parameter int DEPTH = tccs_pkg::COLUMNS_DEF * tccs_pkg::ROWS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [tccs_pkg::CELL_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [tccs_pkg::CELL_W-1:0] rdata
);

  logic [tccs_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read after write in the same cycle returns the new cell
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

### sv/tccs_cursor.sv
module tccs_cursor #(
  parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccs_pkg::ROWS_DEF,
  localparam int COL_W   = $clog2(COLUMNS),
  localparam int ROW_W   = $clog2(ROWS),
  localparam int CELL_AW = $clog2(COLUMNS * ROWS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        put_en,
  input  logic                        home,
  input  logic [tccs_pkg::CHAR_W-1:0] code,
  output tccs_pkg::cur_status_t       status,
  output logic [CELL_AW-1:0]          cur_idx
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W:0]   col_ext, ncol;
  logic [ROW_W:0]   nrow;
  logic             print, scroll;

  always_comb begin
    col_ext = {1'b0, col_r};
    ncol    = col_ext;
    nrow    = {1'b0, row_r};
    print   = 1'b0;
    unique case (code)
      tccs_pkg::CH_BS: begin
        if (col_r != '0) ncol = col_ext - 1'b1;
      end
      tccs_pkg::CH_TAB: begin
        ncol = (col_ext + (COL_W+1)'(tccs_pkg::TAB_STOP))
               & ~((COL_W+1)'(tccs_pkg::TAB_STOP - 1));
      end
      tccs_pkg::CH_CR: begin
        ncol = '0;
      end
      tccs_pkg::CH_LF: begin
        ncol = '0;
        nrow = nrow + 1'b1;
      end
      default: begin
        if ((code >= tccs_pkg::CH_SPACE) && (code <= tccs_pkg::CH_PRINT_MAX)) begin
          print = 1'b1;
          ncol  = col_ext + 1'b1;
        end
      end
    endcase
    // wrap past the last column
    if (ncol >= (COL_W+1)'(COLUMNS)) begin
      ncol = '0;
      nrow = nrow + 1'b1;
    end
    scroll = (nrow >= (ROW_W+1)'(ROWS));
    if (scroll) nrow = (ROW_W+1)'(ROWS - 1);
  end

  assign status.print  = print;
  assign status.scroll = scroll;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (home) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (put_en) begin
      col_nxt = ncol[COL_W-1:0];
      row_nxt = nrow[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign cur_idx = CELL_AW'(row_r) * CELL_AW'(COLUMNS) + CELL_AW'(col_r);

endmodule

### sv/text_console_cursor_scroll.sv
// put without scroll, read and unknown commands go from IDLE to RESP, which
// loads the output register once it is free; requests are taken only in IDLE
// a scrolling put goes to COPY (rows up one), FILL (bottom row blank), READ
// clear goes to FILL, which blanks every cell from the first, then to READ
// reset (rst_n low, synchronous) homes the cursor and starts a clearing pass
// that writes blank 0x0F20 to every cell; in_ready stays low meanwhile
module text_console_cursor_scroll #(
  parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tccs_pkg::tccs_in_t             in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output tccs_pkg::tccs_out_t            out_data,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [tccs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tccs_pkg::ATTR_W-1:0]    cfg_wdata
);

  localparam int CELLS   = COLUMNS * ROWS;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int ADDR_W  = tccs_pkg::ADDR_W;
  localparam int CELL_W  = tccs_pkg::CELL_W;

  // sequencer states
  localparam logic [2:0] ST_INIT = 3'd0;  // clearing pass after reset
  localparam logic [2:0] ST_IDLE = 3'd1;  // waiting for a request
  localparam logic [2:0] ST_COPY = 3'd2;  // scroll: move rows up one
  localparam logic [2:0] ST_FILL = 3'd3;  // blank fill up to the last cell
  localparam logic [2:0] ST_READ = 3'd4;  // read the addressed cell
  localparam logic [2:0] ST_RESP = 3'd5;  // hand the result to the output register

  logic [2:0] state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // configuration registers
  logic [tccs_pkg::ATTR_W-1:0] char_attr_r, char_attr_nxt;
  logic [tccs_pkg::ATTR_W-1:0] blank_attr_r, blank_attr_nxt;

  // request address, kept for the read after a sweep
  logic [CELL_AW-1:0] addr_idx_r, addr_idx_nxt;
  logic               addr_ok_r, addr_ok_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  tccs_pkg::tccs_out_t out_data_r, out_data_nxt;

  // cell store port
  logic               mem_we, mem_re;
  logic [CELL_AW-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0]  mem_wdata, mem_rdata;

  // cursor unit
  logic                  cur_put, cur_home;
  tccs_pkg::cur_status_t cur_status;
  logic [CELL_AW-1:0]    cur_idx;

  logic                        in_fire;
  logic [CELL_AW+ADDR_W-1:0]   in_addr_wide;
  logic [ADDR_W+CELL_AW-1:0]   loc_wide;
  logic [CNT_W-1:0]            copy_dst;
  logic [CELL_W-1:0]           blank_cell;
  logic                        out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // address of the request, range checked against the store size
  assign in_addr_wide = {{CELL_AW{1'b0}}, in_data.cell_address};
  // linear cursor position, fitted to the output field
  assign loc_wide     = {{ADDR_W{1'b0}}, cur_idx};
  // destination of a scroll copy is one row above the cell read on the previous cycle
  assign copy_dst     = cnt_r - CNT_W'(COLUMNS + 1);
  assign blank_cell   = {blank_attr_r, tccs_pkg::CH_SPACE};

  tccs_cell_store #(
    .DEPTH(CELLS)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  tccs_cursor #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_cursor (
    .clk    (clk),
    .rst_n  (rst_n),
    .put_en (cur_put),
    .home   (cur_home),
    .code   (in_data.char_code),
    .status (cur_status),
    .cur_idx(cur_idx)
  );

  // configuration decode
  always_comb begin
    char_attr_nxt  = char_attr_r;
    blank_attr_nxt = blank_attr_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tccs_pkg::CFG_CHAR_ATTR:  char_attr_nxt  = cfg_wdata;
        tccs_pkg::CFG_BLANK_ATTR: blank_attr_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    addr_idx_nxt  = addr_idx_r;
    addr_ok_nxt   = addr_ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = blank_cell;
    mem_re        = 1'b0;
    mem_raddr     = addr_idx_r;
    cur_put       = 1'b0;
    cur_home      = 1'b0;

    unique case (state_r)
      ST_INIT: begin
        // reset blank does not follow the attribute register
        mem_we    = 1'b1;
        mem_waddr = cnt_r[CELL_AW-1:0];
        mem_wdata = {tccs_pkg::BLANK_ATTR_RST, tccs_pkg::CH_SPACE};
        if (cnt_r == CNT_W'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          addr_idx_nxt = in_addr_wide[CELL_AW-1:0];
          addr_ok_nxt  = (in_addr_wide < (CELL_AW+ADDR_W)'(CELLS));
          mem_raddr    = in_addr_wide[CELL_AW-1:0];
          unique case (in_data.command)
            tccs_pkg::CMD_PUT: begin
              cur_put = 1'b1;
              // printable character goes into the cell under the cursor
              if (cur_status.print) begin
                mem_we    = 1'b1;
                mem_waddr = cur_idx;
                mem_wdata = {char_attr_r, in_data.char_code};
              end
              if (cur_status.scroll) begin
                state_nxt = ST_COPY;
                cnt_nxt   = CNT_W'(COLUMNS);
              end else begin
                // same-cycle read sees the new cell through the store bypass
                mem_re    = addr_ok_nxt;
                state_nxt = ST_RESP;
              end
            end
            tccs_pkg::CMD_CLEAR: begin
              cur_home  = 1'b1;
              cnt_nxt   = '0;
              state_nxt = ST_FILL;
            end
            tccs_pkg::CMD_READ: begin
              mem_re    = addr_ok_nxt;
              state_nxt = ST_RESP;
            end
            default: begin
              // unused command code behaves as a read
              mem_re    = addr_ok_nxt;
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_COPY: begin
        // read cell cnt, write the cell read on the previous cycle one row higher
        if (cnt_r < CNT_W'(CELLS)) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_r[CELL_AW-1:0];
        end
        if (cnt_r > CNT_W'(COLUMNS)) begin
          mem_we    = 1'b1;
          mem_waddr = copy_dst[CELL_AW-1:0];
          mem_wdata = mem_rdata;
        end
        if (cnt_r == CNT_W'(CELLS)) begin
          // bottom row gets blanks
          cnt_nxt   = CNT_W'(CELLS - COLUMNS);
          state_nxt = ST_FILL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[CELL_AW-1:0];
        mem_wdata = blank_cell;
        if (cnt_r == CNT_W'(CELLS - 1)) begin
          state_nxt = ST_READ;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_READ: begin
        mem_re    = addr_ok_r;
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        // result waits here until the output register is free
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.cursor_location = loc_wide[ADDR_W-1:0];
          out_data_nxt.cell_value      = addr_ok_r ? mem_rdata : '0;
          state_nxt                    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      cnt_r        <= '0;
      char_attr_r  <= tccs_pkg::CHAR_ATTR_RST;
      blank_attr_r <= tccs_pkg::BLANK_ATTR_RST;
      out_valid_r  <= 1'b0;
      addr_ok_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      char_attr_r  <= char_attr_nxt;
      blank_attr_r <= blank_attr_nxt;
      out_valid_r  <= out_valid_nxt;
      addr_ok_r    <= addr_ok_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_idx_r <= addr_idx_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
